>>> design/cbsf_pkg.sv
// Shared constants for the centered box smoothing filter.
`default_nettype none

package cbsf_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int RING_DEPTH  = 64;
    localparam int INDEX_BITS  = 16;

    localparam int SAMPLE_W    = 8;
    localparam int WIN_W       = 6;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int HALF_W      = $clog2(MAX_WINDOW / 2 + 1);
    localparam int TERM_W      = $clog2(MAX_WINDOW + 2);
    localparam int SUM_W       = $clog2((MAX_WINDOW + 1) * 255 + 1);
    localparam int ITER_W      = $clog2(SUM_W + 1);
    localparam int MAX_RESULTS = MAX_WINDOW / 2 + 1;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

endpackage

`default_nettype wire

>>> design/cbsf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module cbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/cbsf_div.sv
// Restoring divider, one quotient bit per cycle: sum of terms over term count.
`default_nettype none

module cbsf_div
    import cbsf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire logic [SUM_W-1:0]    i_dividend,
    input  wire logic [TERM_W-1:0]   i_divisor,
    output logic                     o_done,
    output logic [SAMPLE_W-1:0]      o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [TERM_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [TERM_W-1:0] r_div;

    logic [TERM_W:0]   n_shift;
    logic              n_ge;
    logic [TERM_W:0]   n_diff;

    always_comb begin
        n_shift = {r_rem, r_quo[SUM_W-1]};
        n_ge    = (n_shift >= {1'b0, r_div});
        n_diff  = n_shift - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == ITER_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_iter <= r_iter + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[TERM_W-1:0] : n_shift[TERM_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[SAMPLE_W-1:0];

endmodule

`default_nettype wire

>>> design/centered_box_smoothing_filter.sv
// Top level: sample ring, result sequencer and output register of the smoother.
//
// Usage
//   s_axis: one request per raw sample; tdata[7:0] = sample, tlast = last sample
//           of the sequence. Taken only while the sequencer is idle.
//   m_axis: one request per smoothed sample; tdata[7:0] = filtered,
//           tlast = final smoothed sample of the sequence.
//   i_cfg_we / i_cfg_wdata: window length (6 bits), written while idle.
//           Above 32 acts as 32; below 2 passes samples through.
// Each accepted sample is written to the 64-entry ring, then every position
// whose right neighbours are present is smoothed (a tlast sample flushes all,
// up to 17 results). Each result with T terms (T = 1..33) passes the check
// step, T reads of the ring through its single read port, the bit-serial
// divider and the output step. A sample that yields no result passes only
// the check step before the next is accepted.
// Reset (synchronous, active low) clears the counters, sets the window to 1
// and empties the output register; ring contents are not cleared.
// A stalled receiver holds the result in the output register; the sequencer
// waits there and new samples may be taken once the current one is done.
`default_nettype none

module centered_box_smoothing_filter
    import cbsf_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // configuration
    input  wire logic                i_cfg_we,
    input  wire logic [WIN_W-1:0]    i_cfg_wdata,      // [5:0] window_size
    // input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [7:0]          s_axis_tdata,     // [7:0] sample
    input  wire logic                s_axis_tlast,     // last_sample
    // output stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [7:0]               m_axis_tdata,     // [7:0] filtered
    output logic                     m_axis_tlast      // last_result
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_READ    = 3'd2;
    localparam logic [2:0] S_DIVGO   = 3'd3;
    localparam logic [2:0] S_DIVWAIT = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [WIN_W-1:0]      r_window;
    logic [INDEX_BITS-1:0] r_rc, n_rc;      // samples received
    logic [INDEX_BITS-1:0] r_ec, n_ec;      // results emitted (= current position)
    logic                  r_last, n_last;
    logic [NRES_W-1:0]     r_nres, n_nres;
    logic [TERM_W-1:0]     r_j, n_j;        // term index being read
    logic                  r_pend, n_pend;  // read data arrives this cycle
    logic                  r_out_vld, n_out_vld;

    // payload
    logic [TERM_W-1:0]     r_terms, n_terms;
    logic                  r_ex, n_ex;
    logic                  r_res_last, n_res_last;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [SAMPLE_W-1:0]   r_out_data, n_out_data;
    logic                  r_out_last, n_out_last;

    // window decode
    logic [WIN_W-1:0]      win_c;
    logic [HALF_W-1:0]     half;
    logic                  odd;

    // position bookkeeping
    logic [INDEX_BITS-1:0] pending, pend_m1;
    logic                  stop;
    logic [HALF_W-1:0]     np_left, np;
    logic                  ex_c;
    logic [TERM_W-1:0]     terms_c;

    // ring access
    logic                  in_acc;
    logic                  rd_en;
    logic [RING_AW-1:0]    rd_addr;
    logic [SAMPLE_W-1:0]   rd_data;
    logic [TERM_W-1:0]     j_inc;
    logic [RING_AW-1:0]    pair_dist;
    logic                  is_extra;

    logic                  div_start;
    logic                  div_done;
    logic [SAMPLE_W-1:0]   div_quo;
    logic                  out_load;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        win_c = (r_window > WIN_W'(MAX_WINDOW)) ? WIN_W'(MAX_WINDOW) : r_window;
        half  = (win_c < WIN_W'(2)) ? '0 : HALF_W'(win_c >> 1);
        odd   = win_c[0] && (win_c >= WIN_W'(2));
    end

    // pairs are counted while inside both ends of the sequence
    always_comb begin
        pending = r_rc - r_ec;
        pend_m1 = pending - 1'b1;
        stop    = (r_nres == NRES_W'(MAX_RESULTS)) || (pending == '0) ||
                  (!r_last && (pending <= INDEX_BITS'(half)));
        np_left = (r_ec < INDEX_BITS'(half)) ? HALF_W'(r_ec) : half;
        np      = (pend_m1 < INDEX_BITS'(np_left)) ? HALF_W'(pend_m1) : np_left;
        ex_c    = odd && (INDEX_BITS'(half) < pending);
        terms_c = TERM_W'({np, 1'b0}) + TERM_W'(1) + TERM_W'(ex_c);
    end

    // term order: center, then (pos-d, pos+d) pairs, then the extra right term
    always_comb begin
        j_inc     = r_j + 1'b1;
        pair_dist = RING_AW'(j_inc >> 1);
        is_extra  = r_ex && (r_j == r_terms - 1'b1);
        if (is_extra) begin
            rd_addr = r_ec[RING_AW-1:0] + RING_AW'(half);
        end else if (r_j[0]) begin
            rd_addr = r_ec[RING_AW-1:0] - pair_dist;
        end else begin
            rd_addr = r_ec[RING_AW-1:0] + pair_dist;
        end
        rd_en = (r_state == S_READ) && (r_j < r_terms);
    end

    assign out_load = (r_state == S_OUT) && (!r_out_vld || m_axis_tready);

    always_comb begin
        n_state    = r_state;
        n_rc       = r_rc;
        n_ec       = r_ec;
        n_last     = r_last;
        n_nres     = r_nres;
        n_j        = r_j;
        n_pend     = 1'b0;
        n_terms    = r_terms;
        n_ex       = r_ex;
        n_res_last = r_res_last;
        n_sum      = r_sum;
        n_out_data = r_out_data;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld;
        div_start  = 1'b0;

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_rc    = r_rc + 1'b1;
                    n_last  = s_axis_tlast;
                    n_nres  = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stop) begin
                    if (r_last) begin
                        n_rc = '0;
                        n_ec = '0;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_terms    = terms_c;
                    n_ex       = ex_c;
                    n_res_last = r_last && (pending == INDEX_BITS'(1));
                    n_j        = '0;
                    n_sum      = '0;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (rd_en) begin
                    n_j    = j_inc;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    n_sum = r_sum + SUM_W'(rd_data);
                end
                if (!rd_en && !r_pend) begin
                    n_state = S_DIVGO;
                end
            end
            S_DIVGO: begin
                div_start = 1'b1;
                n_state   = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_out_data = div_quo;
                    n_out_last = r_res_last;
                    n_out_vld  = 1'b1;
                    n_ec       = r_ec + 1'b1;
                    n_nres     = r_nres + 1'b1;
                    n_state    = S_CHECK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_window  <= WIN_W'(1);
            r_rc      <= '0;
            r_ec      <= '0;
            r_last    <= 1'b0;
            r_nres    <= '0;
            r_j       <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rc      <= n_rc;
            r_ec      <= n_ec;
            r_last    <= n_last;
            r_nres    <= n_nres;
            r_j       <= n_j;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_terms    <= n_terms;
        r_ex       <= n_ex;
        r_res_last <= n_res_last;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    cbsf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_rc[RING_AW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    cbsf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_terms),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // never more results per sample than the flush limit
    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= NRES_W'(MAX_RESULTS))
        else $error("result count past limit");

    // read data only follows a read issued in the read phase
    a_pend_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == S_READ))
        else $error("ring read data without read");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIVWAIT))
        else $error("divider done out of turn");

    // term count stays within one center plus a full window
    a_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_terms >= TERM_W'(1) && r_terms <= TERM_W'(MAX_WINDOW + 1)))
        else $error("term count out of range");

    // the end of a sequence restarts both counters
    a_seq_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && stop && r_last) |=> (r_rc == '0 && r_ec == '0))
        else $error("counters not cleared after last sample");
`endif

endmodule

`default_nettype wire
